// ===== hw/rtl/gf256_lagrange_interpolator_assert.svh =====
// assertion macros used by the checker file
`ifndef GF256_LAGRANGE_INTERPOLATOR_ASSERT_SVH
`define GF256_LAGRANGE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GFLI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gf256 interpolator: implication failed");

// next-cycle implication, disabled during reset
`define GFLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gf256 interpolator: next-cycle check failed");

`endif

// ===== hw/rtl/gfli_pkg.sv =====
// ----------------------------------------------------------------------------
// gfli_pkg
// Shared constants, types and the GF(2^8) multiply for the interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package gfli_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // low byte of the reduction polynomial, and the carry-out bit
   localparam logic [7:0] GF_POLY_LOW = 8'h1B;
   localparam logic [7:0] GF_MSB      = 8'h80;

   // inversion runs b^254 as square, multiply, ..., square: 13 steps
   localparam logic [3:0] INV_LAST_STEP = 4'd12;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
   } point_type;

   typedef struct packed {
      logic       start;
      cnt_type    n;
      logic [7:0] eval_point;
   } eval_cmd_type;

   typedef struct packed {
      logic       done;
      logic [7:0] result;
   } eval_sts_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] m;
      acc = 8'h00;
      m   = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ m;
         end
         if ((m & GF_MSB) != 8'h00) begin
            m = (m << 1) ^ GF_POLY_LOW;
         end else begin
            m = m << 1;
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gfli_point_ram.sv =====
// ----------------------------------------------------------------------------
// gfli_point_ram
// Point store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gfli_point_ram (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire gfli_pkg::idx_type  wr_addr,
   input  wire gfli_pkg::point_type wr_data,
   input  wire gfli_pkg::idx_type  rd_addr,
   output gfli_pkg::point_type     rd_data
);

   gfli_pkg::point_type mem [gfli_pkg::MAX_POINTS];
   gfli_pkg::point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gfli_eval.sv =====
// ----------------------------------------------------------------------------
// gfli_eval
// Lagrange evaluation sequencer: scans the point store once per term,
// accumulates numerator and denominator products, inverts the denominator
// by repeated squaring and folds each term into the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module gfli_eval (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gfli_pkg::eval_cmd_type cmd,
   input  wire logic                  ack,
   output gfli_pkg::eval_sts_type     sts,
   output gfli_pkg::idx_type          rd_addr,
   input  wire gfli_pkg::point_type   rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD_I,
      S_CAP_I,
      S_PROD,
      S_INV,
      S_TERM,
      S_DONE
   } state_type;

   state_type         state_ff;
   gfli_pkg::idx_type i_ff;
   gfli_pkg::idx_type jr_ff;
   gfli_pkg::cnt_type n_ff;
   logic [7:0]        e_ff;
   logic [7:0]        xi_ff;
   logic [7:0]        yi_ff;
   logic [7:0]        num_ff;
   logic [7:0]        den_ff;
   logic [7:0]        inv_ff;
   logic [7:0]        sum_ff;
   logic [3:0]        step_ff;

   logic [7:0] m1a, m1b, m2a, m2b;
   logic [7:0] mul1, mul2;
   logic       last_i, last_j;

   assign last_i = (gfli_pkg::cnt_type'(i_ff) + 1'b1) == n_ff;
   assign last_j = (gfli_pkg::cnt_type'(jr_ff) + 1'b1) == n_ff;

   always_comb begin
      m1a     = 8'h00;
      m1b     = 8'h00;
      m2a     = 8'h00;
      m2b     = 8'h00;
      rd_addr = i_ff;
      unique case (state_ff)
         S_CAP_I: begin
            rd_addr = '0;
         end
         S_PROD: begin
            rd_addr = jr_ff + 1'b1;
            m1a     = num_ff;
            m1b     = e_ff ^ rd_data.x;
            m2a     = den_ff;
            m2b     = xi_ff ^ rd_data.x;
         end
         S_INV: begin
            m1a = num_ff;
            m1b = yi_ff;
            // first step squares the denominator itself
            m2a = (step_ff == 4'd0) ? den_ff : inv_ff;
            m2b = step_ff[0] ? den_ff : m2a;
         end
         S_TERM: begin
            m2a = num_ff;
            m2b = inv_ff;
         end
         default: begin
         end
      endcase
   end

   assign mul1 = gfli_pkg::gf_mul(m1a, m1b);
   assign mul2 = gfli_pkg::gf_mul(m2a, m2b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.start) begin
                  n_ff     <= cmd.n;
                  e_ff     <= cmd.eval_point;
                  i_ff     <= '0;
                  sum_ff   <= 8'h00;
                  state_ff <= S_LOAD_I;
               end
            end
            S_LOAD_I: begin
               state_ff <= S_CAP_I;
            end
            S_CAP_I: begin
               xi_ff    <= rd_data.x;
               yi_ff    <= rd_data.y;
               num_ff   <= 8'h01;
               den_ff   <= 8'h01;
               jr_ff    <= '0;
               state_ff <= S_PROD;
            end
            S_PROD: begin
               if (jr_ff != i_ff) begin
                  num_ff <= mul1;
                  den_ff <= mul2;
               end
               if (last_j) begin
                  step_ff  <= 4'd0;
                  state_ff <= S_INV;
               end else begin
                  jr_ff <= jr_ff + 1'b1;
               end
            end
            S_INV: begin
               if (step_ff == 4'd0) begin
                  num_ff <= mul1;
               end
               inv_ff <= mul2;
               if (step_ff == gfli_pkg::INV_LAST_STEP) begin
                  state_ff <= S_TERM;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            S_TERM: begin
               sum_ff <= sum_ff ^ mul2;
               if (last_i) begin
                  state_ff <= S_DONE;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_LOAD_I;
               end
            end
            S_DONE: begin
               if (ack) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign sts.done   = (state_ff == S_DONE);
   assign sts.result = sum_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gf256_lagrange_interpolator.sv =====
// Collects share points (x, y) one item per cycle into a 16-entry point
// memory; the item marked last starts a Lagrange evaluation over GF(2^8)
// (polynomial 0x11B) at the configured eval point and yields one result item.
// Points past capacity are dropped and flagged on the result. Non-last items
// never stall intake. The result of a set appears once its evaluation is done
// and the output register is free: every term rescans the point memory
// through its single read port and inverts its denominator in 13 multiply
// steps. The input is held off during evaluation; a finished result waits in
// the output register without blocking new points.
// ----------------------------------------------------------------------------
// gf256_lagrange_interpolator
// Top level: point intake, count and overflow tracking, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gf256_lagrange_interpolator (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_share_x,
   input  wire logic [7:0] req_share_y,
   input  wire logic       req_last_point,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_secret_byte,
   output logic            rsp_points_dropped,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata
);

   typedef enum logic {
      T_ACCEPT,
      T_EVAL
   } state_type;

   state_type         state_ff;
   gfli_pkg::cnt_type count_ff;
   logic              overflow_ff;
   logic              drop_ff;
   logic              start_ff;
   gfli_pkg::cnt_type n_ff;
   logic [7:0]        eval_point_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_secret_ff;
   logic              rsp_dropped_ff;

   logic                   accept;
   logic                   full;
   logic                   ack;
   gfli_pkg::eval_cmd_type cmd;
   gfli_pkg::eval_sts_type sts;
   gfli_pkg::idx_type      rd_addr;
   gfli_pkg::point_type    rd_data;
   gfli_pkg::point_type    wr_data;

   assign req_ready = (state_ff == T_ACCEPT);
   assign accept    = req_valid & req_ready;
   assign full      = (count_ff == gfli_pkg::cnt_type'(gfli_pkg::MAX_POINTS));
   assign ack       = (state_ff == T_EVAL) & sts.done & (~rsp_valid_ff | rsp_ready);

   assign wr_data.x = req_share_x;
   assign wr_data.y = req_share_y;

   assign cmd.start      = start_ff;
   assign cmd.n          = n_ff;
   assign cmd.eval_point = eval_point_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_point_ff <= 8'h00;
      end else if (csr_we) begin
         eval_point_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_ACCEPT;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= accept & req_last_point;
         // a new result may replace one leaving in the same cycle
         rsp_valid_ff <= ack | (rsp_valid_ff & ~rsp_ready);
         unique case (state_ff)
            T_ACCEPT: begin
               if (accept) begin
                  if (req_last_point) begin
                     // a dropped last point still closes the set
                     n_ff        <= full ? count_ff : count_ff + 1'b1;
                     drop_ff     <= overflow_ff | full;
                     count_ff    <= '0;
                     overflow_ff <= 1'b0;
                     state_ff    <= T_EVAL;
                  end else if (full) begin
                     overflow_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            T_EVAL: begin
               if (ack) begin
                  rsp_secret_ff  <= sts.result;
                  rsp_dropped_ff <= drop_ff;
                  state_ff       <= T_ACCEPT;
               end
            end
            default: begin
               state_ff <= T_ACCEPT;
            end
         endcase
      end
   end

   gfli_point_ram u_point_ram (
      .clock   (clock),
      .wr_en   (accept & ~full),
      .wr_addr (count_ff[gfli_pkg::IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gfli_eval u_eval (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .ack     (ack),
      .sts     (sts),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_secret_byte    = rsp_secret_ff;
   assign rsp_points_dropped = rsp_dropped_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gfli_checker.sv =====
// ----------------------------------------------------------------------------
// gfli_checker
// Port-level checks on the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gf256_lagrange_interpolator_assert.svh"

module gfli_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_share_x,
   input wire logic [7:0] req_share_y,
   input wire logic       req_last_point,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_secret_byte,
   input wire logic       rsp_points_dropped,
   input wire logic       csr_we,
   input wire logic [7:0] csr_wdata
);

   logic unused_inputs;
   assign unused_inputs = ^{req_share_x, req_share_y, csr_we, csr_wdata};

   // a stalled result holds
   `GFLI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_secret_byte) && $stable(rsp_points_dropped))

   // a last item closes intake until its result is produced
   `GFLI_ASSERT_NEXT(a_last_blocks, clock, reset, req_valid && req_ready && req_last_point, !req_ready)

   // an item that is not last never stalls intake
   `GFLI_ASSERT_NEXT(a_point_streams, clock, reset, req_valid && req_ready && !req_last_point, req_ready)

   // a new result appears exactly as intake reopens
   `GFLI_ASSERT_SAME(a_rsp_reopens, clock, reset, $rose(rsp_valid), $rose(req_ready))

endmodule

bind gf256_lagrange_interpolator gfli_checker u_checker (.*);

`default_nettype wire

// ===== sim/tb_gf256_lagrange_interpolator.sv =====
// ----------------------------------------------------------------------------
// tb_gf256_lagrange_interpolator
// Drives share points into the interpolator through random sender gaps and
// receiver stalls, predicts each recovered byte with an independent GF(2^8)
// Lagrange evaluation, and compares every result item field by field.
// ----------------------------------------------------------------------------
module tb_gf256_lagrange_interpolator;

   localparam int QUIET_LIMIT = 4000;

   class share_recovery_scoreboard;
      typedef struct packed {
         logic [7:0] secret;
         logic       dropped;
      } recovery_type;

      logic [7:0]   share_xs[gfli_pkg::MAX_POINTS];
      logic [7:0]   share_ys[gfli_pkg::MAX_POINTS];
      int unsigned  stored;
      bit           overflowed;
      logic [7:0]   at_point;
      recovery_type expected_recoveries[$];
      int unsigned  mismatches;

      function new();
         stored      = 0;
         overflowed  = 1'b0;
         at_point    = 8'h00;
         mismatches  = 0;
      endfunction

      function void set_eval_point(input logic [7:0] value);
         at_point = value;
      endfunction

      function int unsigned pending();
         return expected_recoveries.size();
      endfunction

      // carry-less product, then fold the high byte back with 0x11b
      function logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
         logic [15:0] prod;
         prod = 16'h0000;
         for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
               prod = prod ^ (16'(a) << i);
            end
         end
         for (int i = 14; i >= 8; i--) begin
            if (prod[i]) begin
               prod = prod ^ (16'h011B << (i - 8));
            end
         end
         return prod[7:0];
      endfunction

      // a / b with b^254 as inverse, zero divisor gives zero
      function logic [7:0] gf_over(input logic [7:0] a, input logic [7:0] b);
         logic [7:0] inv;
         if (b == 8'h00) begin
            return 8'h00;
         end
         inv = 8'h01;
         for (int k = 7; k >= 0; k--) begin
            inv = gf_times(inv, inv);
            if (k != 0) begin
               inv = gf_times(inv, b);
            end
         end
         return gf_times(a, inv);
      endfunction

      function logic [7:0] lagrange_at();
         logic [7:0] total;
         logic [7:0] term;
         total = 8'h00;
         for (int i = 0; i < stored; i++) begin
            term = share_ys[i];
            for (int j = 0; j < stored; j++) begin
               if (i != j) begin
                  term = gf_times(term, gf_over(at_point ^ share_xs[j],
                                                share_xs[i] ^ share_xs[j]));
               end
            end
            total = total ^ term;
         end
         return total;
      endfunction

      function void note_share(input logic [7:0] x, input logic [7:0] y, input logic last);
         recovery_type rec;
         if (stored < gfli_pkg::MAX_POINTS) begin
            share_xs[stored] = x;
            share_ys[stored] = y;
            stored++;
         end else begin
            overflowed = 1'b1;
         end
         if (last) begin
            rec.secret  = lagrange_at();
            rec.dropped = overflowed;
            expected_recoveries.insert(expected_recoveries.size(), rec);
            stored     = 0;
            overflowed = 1'b0;
         end
      endfunction

      function void check_recovery(input logic [7:0] secret, input logic dropped);
         recovery_type rec;
         if (expected_recoveries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: result item with none expected, secret_byte %02h dropped %b",
                        secret, dropped);
            end
            return;
         end
         rec = expected_recoveries.pop_front();
         if (secret !== rec.secret) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: secret_byte expected %02h got %02h", rec.secret, secret);
            end
         end
         if (dropped !== rec.dropped) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: points_dropped expected %b got %b", rec.dropped, dropped);
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_share_x = 8'h00;
   logic [7:0] req_share_y = 8'h00;
   logic       req_last_point = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_secret_byte;
   logic       rsp_points_dropped;
   logic       csr_we = 1'b0;
   logic [7:0] csr_wdata = 8'h00;

   share_recovery_scoreboard sb = new();

   int gap_odds = 0;
   int stall_odds = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   gf256_lagrange_interpolator u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_share_x        (req_share_x),
      .req_share_y        (req_share_y),
      .req_last_point     (req_last_point),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_secret_byte    (rsp_secret_byte),
      .rsp_points_dropped (rsp_points_dropped),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   // receiver stalls in bursts of random length
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(1, 100) <= stall_odds) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 11);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_share(req_share_x, req_share_y, req_last_point);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_recovery(rsp_secret_byte, rsp_points_dropped);
      end
      if (!reset && ((req_valid && req_ready) || (rsp_valid && rsp_ready))) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_share(input logic [7:0] x, input logic [7:0] y, input logic last);
      if ($urandom_range(1, 100) <= gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_share_x    <= x;
      req_share_y    <= y;
      req_last_point <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_eval_point(input logic [7:0] value);
      hold_until_drained();
      repeat (20) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_eval_point(value);
   endtask

   task automatic run_share_sets(input int item_goal, input bit calm);
      int         sent;
      int         pick;
      int         n;
      bit         noisy;
      logic [7:0] x;
      logic [7:0] prev_x;
      sent   = 0;
      prev_x = 8'h00;
      while (sent < item_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            n = $urandom_range(1, 5);
         end else if (pick < 90) begin
            n = $urandom_range(6, 12);
         end else if (pick < 97) begin
            n = $urandom_range(13, 16);
         end else begin
            n = $urandom_range(17, 20);
         end
         noisy = ($urandom_range(0, 19) == 0);
         if (calm || $urandom_range(0, 3) == 0) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else begin
            gap_odds   = $urandom_range(5, 40);
            stall_odds = $urandom_range(5, 40);
         end
         for (int k = 0; k < n; k++) begin
            // noisy sets squeeze x into a few values, so duplicates are common
            if (noisy) begin
               x = 8'($urandom_range(0, 7));
            end else if (k > 0 && $urandom_range(0, 15) == 0) begin
               x = prev_x;
            end else begin
               x = 8'($urandom_range(0, 255));
            end
            send_share(x, 8'($urandom_range(0, 255)), k == n - 1);
            prev_x = x;
         end
         sent = sent + n;
         if (!calm && $urandom_range(0, 9) == 0) begin
            hold_until_drained();
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_eval_point(8'h00);

      // single point, duplicate x, field extremes
      send_share(8'h00, 8'hFF, 1'b1);
      send_share(8'h37, 8'hA5, 1'b0);
      send_share(8'h37, 8'h5A, 1'b1);
      send_share(8'hFF, 8'h00, 1'b0);
      send_share(8'h01, 8'hFF, 1'b0);
      send_share(8'h00, 8'h80, 1'b1);
      // full storage, then the marked last item is dropped
      for (int k = 0; k < gfli_pkg::MAX_POINTS; k++) begin
         send_share(8'(k + 1), 8'($urandom_range(0, 255)), 1'b0);
      end
      send_share(8'hEE, 8'h11, 1'b1);

      run_share_sets(110, 1'b0);
      write_eval_point(8'hFF);
      run_share_sets(110, 1'b0);
      write_eval_point(8'h01);
      run_share_sets(110, 1'b0);
      write_eval_point(8'($urandom_range(2, 254)));
      run_share_sets(110, 1'b0);
      write_eval_point(8'h00);
      run_share_sets(110, 1'b1);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/gfli_pkg.sv
hw/rtl/gfli_point_ram.sv
hw/rtl/gfli_eval.sv
hw/rtl/gf256_lagrange_interpolator.sv
hw/rtl/gfli_checker.sv
sim/tb_gf256_lagrange_interpolator.sv
